/* rtl/core/cch_pkg.sv */
`timescale 1ns / 1ps
package cch_pkg;

  localparam int unsigned DEF_POSITION_BINS = 10;
  localparam int unsigned DEF_SCALE_LEVELS  = 12;
  localparam int unsigned DEF_CONF_BINS     = 10;
  localparam int unsigned DEF_COUNT_BITS    = 20;

  localparam int unsigned NUM_TABLES       = 8;
  localparam int unsigned LEVEL_TABLE_SIZE = 12;
  localparam int unsigned BIN_W            = 4;

  localparam logic [17:0] SENTINEL_SCALE = 18'd72818;
  localparam logic [16:0] CONF_ONE       = 17'd65536;

  localparam logic [16:0] RST_CONF_THRESHOLD = 17'd19661;
  localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd1360;
  localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd800;

  localparam logic [1:0] CFG_CONF_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FILTERED  = 3'd1;
  localparam logic [2:0] ST_NO_SCALE  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_BAD_READ  = 3'd4;

  localparam logic [3:0] TBL_PRIORS = 4'd8;

  localparam logic [17:0] LEVEL_CODES [LEVEL_TABLE_SIZE] = '{
    18'd17920, 18'd21504, 18'd25805, 18'd30966, 18'd37159, 18'd44591,
    18'd53509, 18'd64211, 18'd77053, 18'd92463, 18'd110956, 18'd133147
  };

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic             found;
    logic [BIN_W-1:0] level;
  } level_hit_t;

  function automatic level_hit_t level_lookup(input logic [17:0] code,
                                              input int unsigned lim);
    level_hit_t res;
    res = '0;
    for (int unsigned i = 0; i < LEVEL_TABLE_SIZE; i++) begin
      if (!res.found && i < lim && LEVEL_CODES[i] == code) begin
        res.found = 1'b1;
        res.level = BIN_W'(i);
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/class_conditional_histogram.sv */
`timescale 1ns / 1ps
// Class-conditional histogram of detection records with smoothed read-out.
// Input channel (in_*): one transaction per action. Add counts a record into
// the hit or miss tables, read returns one unsigned Q1.16 probability, clear zeroes
// all counts. Result channel (out_*): exactly one transaction per input.
// Configuration (cfg_*): threshold and image size, written while idle;
// cfg_ready is always high.
// One item is worked on at a time; in_stall is high from acceptance until
// the result is loaded into the output register. Steps per action:
//   add:   the shared bit-serial divider bins x and y (each pass skipped
//          for a clamped coordinate), then four read-modify-write passes
//          over the count RAM
//   read:  a count RAM read then a divide for a bin, a divide for a prior
//   clear, rejected add, bad read, prior with no records: no RAM or divider pass
// The output register takes a result as the block returns to idle, so the
// next input can be accepted while that result is stalled; a stalled result
// holds and blocks only the item after the next.
// Reset clears all counts (per-entry valid bits), the class counts and the
// configuration to its defaults; no clearing pass is needed.
module class_conditional_histogram #(
  parameter int unsigned POSITION_BINS = cch_pkg::DEF_POSITION_BINS,
  parameter int unsigned SCALE_LEVELS  = cch_pkg::DEF_SCALE_LEVELS,
  parameter int unsigned CONF_BINS     = cch_pkg::DEF_CONF_BINS,
  parameter int unsigned COUNT_BITS    = cch_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [12:0] in_x_position,
  input  logic [12:0] in_y_position,
  input  logic [17:0] in_scale_code,
  input  logic [16:0] in_confidence,
  input  logic [5:0]  in_sign_type,
  input  logic        in_reported_hit,
  input  logic [3:0]  in_table_select,
  input  logic [3:0]  in_bin_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_probability,
  output logic [2:0]  out_status,
  output logic        out_classed_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  import cch_pkg::*;

  localparam int unsigned MAX_A   = POSITION_BINS > SCALE_LEVELS ? POSITION_BINS : SCALE_LEVELS;
  localparam int unsigned SLOTS   = MAX_A > CONF_BINS ? MAX_A : CONF_BINS;
  localparam int unsigned DEPTH   = NUM_TABLES * SLOTS;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned NW      = COUNT_BITS + 16;
  localparam int unsigned DW      = COUNT_BITS + 1;
  localparam int unsigned LVL_LIM =
    SCALE_LEVELS > LEVEL_TABLE_SIZE ? LEVEL_TABLE_SIZE : SCALE_LEVELS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_XST   = 4'd2;
  localparam logic [3:0] S_XW    = 4'd3;
  localparam logic [3:0] S_YST   = 4'd4;
  localparam logic [3:0] S_YW    = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_RDATA = 4'd8;
  localparam logic [3:0] S_PDIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic [4:0] table_bins(input logic [3:0] t);
    if (t < 4'd4) return 5'(POSITION_BINS);
    if (t < 4'd6) return 5'(SCALE_LEVELS);
    return 5'(CONF_BINS);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [2:0] t,
                                              input logic [BIN_W-1:0] b);
    return AW'(AW'(t) * AW'(SLOTS) + AW'(b));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  logic [3:0]  state_r, state_nxt;

  logic [16:0] thr_r;
  logic [11:0] width_r;
  logic [11:0] height_r;

  logic [1:0]  act_r;
  logic [12:0] x_r, y_r;
  logic [17:0] scale_r;
  logic [16:0] conf_r;
  logic [5:0]  stype_r;
  logic        rhit_r;
  logic [3:0]  tsel_r, bsel_r;

  logic             classed_r;
  logic [BIN_W-1:0] level_r, xbin_r, ybin_r, cbin_r;
  logic [1:0]       k_r;
  logic             vld_q_r;
  logic [2:0]       res_status_r;
  logic [16:0]      res_prob_r;

  logic [COUNT_BITS-1:0] hit_r, miss_r;
  logic [4:0]            nz_r [NUM_TABLES];
  logic [DEPTH-1:0]      valid_r;

  logic        out_valid_r;
  logic [16:0] out_prob_r;
  logic [2:0]  out_status_r;
  logic        out_classed_r;

  level_hit_t lk;
  logic       filt;
  logic       read_bad;
  logic [20:0] cprod;
  logic [BIN_W-1:0] cbin;
  logic [16:0] xprod, yprod;
  logic [2:0]  tbl_k;
  logic [BIN_W-1:0] bin_k;
  logic [AW-1:0] addr;
  logic        ram_re, ram_we;
  logic [COUNT_BITS-1:0] ram_rdata, old_cnt;
  logic [COUNT_BITS:0]   total;
  logic [COUNT_BITS:0]   den_bin;
  logic [4:0]  empty_bins;
  logic        div_start;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  div_status_t   div_stat;
  logic [16:0]   prob_clamped;
  logic          out_free;

  assign lk       = level_lookup(scale_r, LVL_LIM);
  assign filt     = stype_r == 6'd11 || stype_r > 6'd16 || scale_r == SENTINEL_SCALE;
  assign read_bad = (tsel_r == TBL_PRIORS) ? (bsel_r > 4'd1)
                  : !(tsel_r < 4'(NUM_TABLES) && {1'b0, bsel_r} < table_bins(tsel_r));
  assign cprod    = 21'(conf_r[15:0]) * 21'(CONF_BINS);
  assign cbin     = conf_r[16] ? BIN_W'(CONF_BINS - 1) : cprod[16 +: BIN_W];
  assign xprod    = 17'(x_r[11:0]) * 17'(POSITION_BINS);
  assign yprod    = 17'(y_r[11:0]) * 17'(POSITION_BINS);

  assign tbl_k = {k_r, ~classed_r};
  always_comb begin
    unique case (k_r)
      2'd0:    bin_k = xbin_r;
      2'd1:    bin_k = ybin_r;
      2'd2:    bin_k = level_r;
      default: bin_k = cbin_r;
    endcase
  end

  assign addr    = (state_r == S_DEC) ? slot_addr(tsel_r[2:0], bsel_r)
                                      : slot_addr(tbl_k, bin_k);
  assign ram_re  = state_r == S_RD ||
                   (state_r == S_DEC && act_r == ACT_READ && !read_bad &&
                    tsel_r != TBL_PRIORS);
  assign ram_we  = state_r == S_WR;
  assign old_cnt = vld_q_r ? ram_rdata : '0;

  assign total      = {1'b0, hit_r} + {1'b0, miss_r};
  assign empty_bins = table_bins(tsel_r) - nz_r[tsel_r[2:0]];
  assign den_bin    = (tsel_r[0] ? {1'b0, miss_r} : {1'b0, hit_r}) + DW'(empty_bins);

  cch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (sat_inc(old_cnt)),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = {(bsel_r == 4'd0) ? hit_r : miss_r, 16'd0};
    div_den   = total;
    unique case (state_r)
      S_XST: begin
        div_start = x_r[11:0] < width_r;
        div_num   = NW'(xprod);
        div_den   = DW'(width_r);
      end
      S_YST: begin
        div_start = y_r[11:0] < height_r;
        div_num   = NW'(yprod);
        div_den   = DW'(height_r);
      end
      S_DEC: begin
        div_start = act_r == ACT_READ && tsel_r == TBL_PRIORS && !read_bad &&
                    total != '0;
      end
      S_RDATA: begin
        div_start = den_bin != '0;
        div_num   = {(old_cnt == '0) ? COUNT_BITS'(1) : old_cnt, 16'd0};
        div_den   = den_bin;
      end
      default: ;
    endcase
  end

  cch_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign prob_clamped = (div_quo > NW'(CONF_ONE)) ? CONF_ONE : div_quo[16:0];
  assign out_free     = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        unique case (act_r)
          ACT_ADD:  state_nxt = (filt || !lk.found || x_r[12] || y_r[12]) ? S_OUT : S_XST;
          ACT_READ: state_nxt = read_bad ? S_OUT
                              : (tsel_r != TBL_PRIORS) ? S_RDATA
                              : (total != '0) ? S_PDIV : S_OUT;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_XST:   state_nxt = div_start ? S_XW : S_YST;
      S_XW:    if (div_stat.done) state_nxt = S_YST;
      S_YST:   state_nxt = div_start ? S_YW : S_RD;
      S_YW:    if (div_stat.done) state_nxt = S_RD;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = (k_r == 2'd3) ? S_OUT : S_RD;
      S_RDATA: state_nxt = div_start ? S_PDIV : S_OUT;
      S_PDIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= RST_CONF_THRESHOLD;
      width_r     <= RST_IMAGE_WIDTH;
      height_r    <= RST_IMAGE_HEIGHT;
      hit_r       <= '0;
      miss_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) nz_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CONF_THRESHOLD: thr_r    <= cfg_data;
          CFG_IMAGE_WIDTH:    width_r  <= cfg_data[11:0];
          CFG_IMAGE_HEIGHT:   height_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (state_r == S_DEC && act_r == ACT_CLEAR) begin
        hit_r   <= '0;
        miss_r  <= '0;
        valid_r <= '0;
        for (int i = 0; i < NUM_TABLES; i++) nz_r[i] <= '0;
      end
      if (state_r == S_WR) begin
        valid_r[addr] <= 1'b1;
        if (old_cnt == '0) nz_r[tbl_k] <= nz_r[tbl_k] + 1'b1;
        if (k_r == 2'd3) begin
          if (classed_r) hit_r <= sat_inc(hit_r);
          else           miss_r <= sat_inc(miss_r);
        end
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        act_r   <= in_action;
        x_r     <= in_x_position;
        y_r     <= in_y_position;
        scale_r <= in_scale_code;
        conf_r  <= in_confidence;
        stype_r <= in_sign_type;
        rhit_r  <= in_reported_hit;
        tsel_r  <= in_table_select;
        bsel_r  <= in_bin_select;
      end
      S_DEC: begin
        res_prob_r   <= '0;
        res_status_r <= ST_OK;
        classed_r    <= 1'b0;
        level_r      <= lk.level;
        cbin_r       <= cbin;
        xbin_r       <= BIN_W'(POSITION_BINS - 1);
        ybin_r       <= BIN_W'(POSITION_BINS - 1);
        k_r          <= 2'd0;
        if (act_r == ACT_ADD) begin
          if (filt)           res_status_r <= ST_FILTERED;
          else if (!lk.found) res_status_r <= ST_NO_SCALE;
          else if (x_r[12] || y_r[12]) res_status_r <= ST_RANGE;
          else classed_r <= rhit_r && (conf_r > thr_r);
        end else if (act_r == ACT_READ && read_bad) begin
          res_status_r <= ST_BAD_READ;
        end
      end
      S_XW:    if (div_stat.done) xbin_r <= div_quo[BIN_W-1:0];
      S_YW:    if (div_stat.done) ybin_r <= div_quo[BIN_W-1:0];
      S_WR:    k_r <= k_r + 1'b1;
      S_PDIV:  if (div_stat.done) res_prob_r <= prob_clamped;
      S_OUT: begin
        if (out_free) begin
          out_prob_r    <= res_prob_r;
          out_status_r  <= res_status_r;
          out_classed_r <= classed_r;
        end
      end
      default: ;
    endcase
    // sample the entry's valid bit alongside the RAM read
    if (ram_re) vld_q_r <= valid_r[addr];
  end

  assign in_stall        = state_r != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_status      = out_status_r;
  assign out_classed_hit = out_classed_r;

endmodule

/* rtl/core/cch_ram.sv */
`timescale 1ns / 1ps
module cch_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cch_div.sv */
`timescale 1ns / 1ps
module cch_div #(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic [NW-1:0]        quo,
  output cch_pkg::div_status_t stat
);

  import cch_pkg::*;

  localparam int unsigned CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/core/cch_checker.sv */
`timescale 1ns / 1ps
module cch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_probability,
  input logic [2:0]  out_status,
  input logic        out_classed_hit
);

  import cch_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BAD_READ)
    else $error("status code out of range");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_probability == '0 && !out_classed_hit)
    else $error("error result carries payload");

  a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= CONF_ONE)
    else $error("probability above one");

  a_hit_no_prob: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_classed_hit |-> out_probability == '0)
    else $error("classed record carries probability");

endmodule

bind class_conditional_histogram cch_checker u_cch_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_probability (out_probability),
  .out_status      (out_status),
  .out_classed_hit (out_classed_hit)
);
